[src/itoa_pkg.sv]
`default_nettype none
package itoa_pkg;

  // Field saturation limit for min_width
  localparam int MAX_WIDTH = 62;

  // Digit buffer: 20 BCD digits cover 2^64-1; hex uses the low 16
  localparam int NUM_DIGITS = 20;
  localparam int HEX_DIGITS = 16;
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int VALUE_W = 64;
  localparam int BITS_PER_STEP = 2;
  localparam int CONV_STEPS = VALUE_W / BITS_PER_STEP;
  localparam int STEP_CNT_W = $clog2(CONV_STEPS);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef enum logic [1:0] {
    OP_UDEC = 2'd0,
    OP_HEX  = 2'd1,
    OP_SDEC = 2'd2,
    OP_PTR  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_PREFIX,
    ST_PAD,
    ST_DIGIT
  } state_t;

  typedef enum logic [1:0] {
    SEL_PREFIX,
    SEL_PAD,
    SEL_DIGIT
  } char_sel_t;

  typedef struct packed {
    logic      load;
    logic      conv_step;
    logic      count;
    logic      prefix_next;
    logic      pad_next;
    logic      digit_next;
    char_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic is_dec;
    logic conv_last;
    logic has_prefix;
    logic prefix_last;
    logic pad_zero;
    logic digit_last;
  } sts_t;

  // Double-dabble correction: add 3 to every BCD digit that is 5 or more
  function automatic logic [NUM_DIGITS*4-1:0] dabble_adj(input logic [NUM_DIGITS*4-1:0] d);
    logic [NUM_DIGITS*4-1:0] r;
    r = d;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (r[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = r[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[src/itoa_if.sv]
`default_nettype none
interface itoa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] value;
  logic        zero_pad;
  logic [5:0]  min_width;

  modport source (output valid, output opcode, output value, output zero_pad,
                  output min_width, input ready);
  modport sink   (input valid, input opcode, input value, input zero_pad,
                  input min_width, output ready);
endinterface

interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;

  modport source (output valid, output char_out, output last, input ready);
  modport sink   (input valid, input char_out, input last, output ready);
endinterface
`default_nettype wire

[src/itoa_datapath.sv]
`default_nettype none
module itoa_datapath (
  input  wire logic               clk,
  input  wire logic [1:0]         opcode,
  input  wire logic [63:0]        value,
  input  wire logic               zero_pad,
  input  wire logic [5:0]         min_width,
  input  wire itoa_pkg::cmd_t     cmd,
  output itoa_pkg::sts_t          sts,
  output logic [7:0]              char_out,
  output logic                    last
);

  localparam int DW = itoa_pkg::NUM_DIGITS * 4;
  localparam int IW = itoa_pkg::DIGIT_IDX_W;
  localparam int SW = itoa_pkg::STEP_CNT_W;

  logic [1:0]                              mode;
  logic                                    zpad;
  logic                                    neg;
  logic [5:0]                              width;
  logic [itoa_pkg::VALUE_W-1:0]            bin;
  logic [itoa_pkg::NUM_DIGITS-1:0][3:0]    bcd;
  logic [SW-1:0]                           step_cnt;
  logic                                    pos;
  logic [5:0]                              pad_cnt;
  logic [IW-1:0]                           dig_idx;

  logic                                    neg_in;
  logic [63:0]                             mag;
  logic [5:0]                              wsat;
  logic [DW+itoa_pkg::VALUE_W-1:0]         shift1;
  logic [DW+itoa_pkg::VALUE_W-1:0]         shift2;
  logic [IW-1:0]                           nd;
  logic [3:0]                              dig;

  assign neg_in = (opcode == itoa_pkg::OP_SDEC) && value[63];
  assign mag    = neg_in ? (~value + 64'd1) : value;
  assign wsat   = (min_width > 6'(itoa_pkg::MAX_WIDTH)) ? 6'(itoa_pkg::MAX_WIDTH) : min_width;

  // two shift-and-add-3 steps per cycle
  assign shift1 = {itoa_pkg::dabble_adj(bcd), bin} << 1;
  assign shift2 = {itoa_pkg::dabble_adj(shift1[DW+itoa_pkg::VALUE_W-1 -: DW]),
                   shift1[itoa_pkg::VALUE_W-1:0]} << 1;

  // significant digit count, minus one (zero still prints one digit)
  always_comb begin
    nd = '0;
    for (int i = 1; i < itoa_pkg::NUM_DIGITS; i++) begin
      if (bcd[i] != 4'd0) begin
        nd = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode     <= opcode;
      zpad     <= zero_pad;
      neg      <= neg_in;
      width    <= (neg_in && wsat != 6'd0) ? wsat - 6'd1 : wsat;
      bin      <= mag;
      step_cnt <= '0;
      pos      <= 1'b0;
      for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++) begin
        if (i < itoa_pkg::HEX_DIGITS && (opcode == itoa_pkg::OP_HEX ||
                                         opcode == itoa_pkg::OP_PTR)) begin
          bcd[i] <= value[4*i +: 4];
        end else begin
          bcd[i] <= 4'd0;
        end
      end
    end
    if (cmd.conv_step) begin
      bcd      <= shift2[DW+itoa_pkg::VALUE_W-1 -: DW];
      bin      <= shift2[itoa_pkg::VALUE_W-1:0];
      step_cnt <= step_cnt + SW'(1);
    end
    if (cmd.count) begin
      dig_idx <= nd;
      pad_cnt <= (width > 6'(nd) + 6'd1) ? width - 6'(nd) - 6'd1 : 6'd0;
    end
    if (cmd.prefix_next) begin
      pos <= 1'b1;
    end
    if (cmd.pad_next) begin
      pad_cnt <= pad_cnt - 6'd1;
    end
    if (cmd.digit_next) begin
      dig_idx <= dig_idx - IW'(1);
    end
  end

  assign sts.is_dec      = (mode == itoa_pkg::OP_UDEC) || (mode == itoa_pkg::OP_SDEC);
  assign sts.conv_last   = (step_cnt == SW'(itoa_pkg::CONV_STEPS - 1));
  assign sts.has_prefix  = neg || (mode == itoa_pkg::OP_PTR);
  assign sts.prefix_last = neg || pos;
  assign sts.pad_zero    = (pad_cnt == 6'd0);
  assign sts.digit_last  = (dig_idx == '0);

  assign dig = bcd[dig_idx];

  always_comb begin
    case (cmd.sel)
      itoa_pkg::SEL_PREFIX: char_out = neg ? itoa_pkg::CH_MINUS :
                                       (pos ? itoa_pkg::CH_X : itoa_pkg::CH_ZERO);
      itoa_pkg::SEL_PAD:    char_out = zpad ? itoa_pkg::CH_ZERO : itoa_pkg::CH_SPACE;
      itoa_pkg::SEL_DIGIT:  char_out = (dig < 4'd10) ? itoa_pkg::CH_ZERO + {4'd0, dig}
                                       : itoa_pkg::CH_LOW_A + {4'd0, dig} - 8'd10;
      default:              char_out = itoa_pkg::CH_SPACE;
    endcase
  end

  assign last = (cmd.sel == itoa_pkg::SEL_DIGIT) && sts.digit_last;

endmodule
`default_nettype wire

[src/itoa_ctrl.sv]
`default_nettype none
module itoa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire itoa_pkg::sts_t sts,
  output itoa_pkg::cmd_t      cmd
);

  itoa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itoa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      itoa_pkg::ST_IDLE: begin
        if (in_valid) state_next = itoa_pkg::ST_CONV;
      end
      itoa_pkg::ST_CONV: begin
        if (!sts.is_dec || sts.conv_last) state_next = itoa_pkg::ST_COUNT;
      end
      itoa_pkg::ST_COUNT: begin
        state_next = sts.has_prefix ? itoa_pkg::ST_PREFIX : itoa_pkg::ST_PAD;
      end
      itoa_pkg::ST_PREFIX: begin
        if (out_ready && sts.prefix_last) state_next = itoa_pkg::ST_PAD;
      end
      itoa_pkg::ST_PAD: begin
        if (sts.pad_zero) state_next = itoa_pkg::ST_DIGIT;
      end
      itoa_pkg::ST_DIGIT: begin
        if (out_ready && sts.digit_last) state_next = itoa_pkg::ST_IDLE;
      end
      default: state_next = itoa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    cmd.load        = 1'b0;
    cmd.conv_step   = 1'b0;
    cmd.count       = 1'b0;
    cmd.prefix_next = 1'b0;
    cmd.pad_next    = 1'b0;
    cmd.digit_next  = 1'b0;
    cmd.sel         = itoa_pkg::SEL_DIGIT;
    case (state)
      itoa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      itoa_pkg::ST_CONV: begin
        cmd.conv_step = sts.is_dec;
      end
      itoa_pkg::ST_COUNT: begin
        cmd.count = 1'b1;
      end
      itoa_pkg::ST_PREFIX: begin
        out_valid       = 1'b1;
        cmd.sel         = itoa_pkg::SEL_PREFIX;
        cmd.prefix_next = out_ready;
      end
      itoa_pkg::ST_PAD: begin
        out_valid    = !sts.pad_zero;
        cmd.sel      = itoa_pkg::SEL_PAD;
        cmd.pad_next = !sts.pad_zero && out_ready;
      end
      itoa_pkg::ST_DIGIT: begin
        out_valid      = 1'b1;
        cmd.digit_next = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/integer_to_ascii_formatter.sv]
`default_nettype none
// Decimal modes convert the value by double dabble before the digit count; hex skips the
// conversion. With no sign, "0x" or pad leading, the first beat waits for the pad check.
// Characters go out one beat per cycle while chr.ready is high, and the pad phase always
// ends with an empty pad check; a new item is taken only after the previous last beat.
// Reset (rst, synchronous, active high) returns the controller to idle and drops any
// item in flight; the datapath registers are not reset.
module integer_to_ascii_formatter (
  input  wire logic    clk,
  input  wire logic    rst,
  itoa_in_if.sink      item,
  itoa_out_if.source   chr
);

  // Command/status bundle between controller and datapath
  itoa_pkg::cmd_t cmd;
  itoa_pkg::sts_t sts;

  logic in_ready;
  logic out_valid;

  // Controller: sequences load, BCD conversion, digit count, and the three
  // output phases (sign or "0x" prefix, padding, digits msd first)
  itoa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (chr.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: magnitude, width clamp, digit buffer and character select.
  // The output beat payload is selected combinationally from its registers.
  itoa_datapath u_dp (
    .clk       (clk),
    .opcode    (item.opcode),
    .value     (item.value),
    .zero_pad  (item.zero_pad),
    .min_width (item.min_width),
    .cmd       (cmd),
    .sts       (sts),
    .char_out  (chr.char_out),
    .last      (chr.last)
  );

  assign item.ready = in_ready;
  assign chr.valid  = out_valid;

endmodule
`default_nettype wire
